@@ src/gbsa_pkg.sv @@
`default_nettype none

package gbsa_pkg;

	localparam int unsigned MAX_BATCHES_DEF = 8;
	localparam int unsigned MAX_SLOTS_DEF   = 32;
	localparam int unsigned SLOT_LIMIT      = 64;

	localparam int unsigned ESIZE_W  = 16;
	localparam int unsigned ASIZE_W  = 17;
	localparam int unsigned OFFSET_W = 21;
	localparam int unsigned BATCH_W  = 3;
	localparam int unsigned SLOT_W   = 5;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;

	localparam logic [ESIZE_W-1:0] ESIZE_RESET = 16'd4;

	// register index, taken from paddr above the byte lanes
	localparam logic [0:0] REG_ELEMENT_SIZE = 1'b0;

	typedef enum logic [0:0] {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} gbsa_cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_NOMEM   = 2'd1,
		STATUS_INVALID = 2'd2
	} gbsa_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_RD,
		S_A_CHK,
		S_F_END,
		S_F_CHK,
		S_F_DIV,
		S_F_CLR,
		S_FIN,
		S_RESP
	} gbsa_state_t;

	// bitmap of the slots that exist in batch k: min(2 << k, nslots) low bits
	function automatic logic [SLOT_LIMIT-1:0] slot_mask(input logic [5:0] k,
		input int unsigned nslots);
		logic [SLOT_LIMIT-1:0] m;
		m = '0;
		for (int unsigned i = 0; i < SLOT_LIMIT; i++) begin
			m[i] = (i < nslots) && (((i >> 1) >> k) == 0);
		end
		return m;
	endfunction

	// slot count of batch k: min(2 << k, nslots)
	function automatic logic [6:0] slot_count(input logic [5:0] k,
		input int unsigned nslots);
		int unsigned n;
		if (k >= 6'd6) begin
			n = nslots;
		end else begin
			n = 32'd2 << k;
			if (n > nslots) begin
				n = nslots;
			end
		end
		return 7'(n);
	endfunction

	// element size rounded up to a multiple of four
	function automatic logic [ASIZE_W-1:0] align_size(input logic [ESIZE_W-1:0] es);
		return (ASIZE_W'(es) + ASIZE_W'(3)) & ~ASIZE_W'(3);
	endfunction

endpackage

`default_nettype wire

@@ src/growing_batch_slot_allocator.sv @@
// Slot allocator over a growing set of batches, batch k holding min(2 << k, MAX_SLOTS)
// slots, each batch tracked by a busy bitmap in a small memory.
// Command channel: a word is taken at a rising edge with start high and busy low;
// cmd selects allocate or free, free_batch/free_offset name the slot to free.
// Result channel: done is high for exactly one cycle with status, batch_index,
// slot_index, byte_offset and opened_batch; the receiver cannot stall, so the
// word must be taken in that cycle.
// Steps after the accepting edge, done in the last one:
//   allocate: for each batch scanned, a bitmap memory read, then lowest-free-bit
//   pick and write back.
//   allocate with no open batch, or zero element size: straight to the result.
//   free: a restoring divider turns the byte offset into a slot, one quotient
//   bit a cycle.
//   free with the offset past the batch end: the division is skipped.
//   free of a batch that is not open, or zero element size: straight to the result.
// busy stays high from the accept through the done cycle; the next word can be
// taken in the cycle after done.
// Reset clears the open batch count and sets element_size to 4; bitmaps of
// batches that are not open are never read, so the memory needs no clearing.
// element_size sits at APB byte address 0; the user must write it only while idle (not enforced here).
`default_nettype none

module growing_batch_slot_allocator #(
	parameter int unsigned MAX_BATCHES = gbsa_pkg::MAX_BATCHES_DEF,
	parameter int unsigned MAX_SLOTS   = gbsa_pkg::MAX_SLOTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 cmd,
	input  logic [gbsa_pkg::BATCH_W-1:0]         free_batch,
	input  logic [gbsa_pkg::OFFSET_W-1:0]        free_offset,
	output logic                                 done,
	output logic [gbsa_pkg::STATUS_W-1:0]        status,
	output logic [gbsa_pkg::BATCH_W-1:0]         batch_index,
	output logic [gbsa_pkg::SLOT_W-1:0]          slot_index,
	output logic [gbsa_pkg::OFFSET_W-1:0]        byte_offset,
	output logic                                 opened_batch,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [gbsa_pkg::PADDR_W-1:0]         paddr,
	input  logic [gbsa_pkg::PDATA_W-1:0]         pwdata,
	output logic [gbsa_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready
);

	localparam int unsigned AW   = gbsa_pkg::ASIZE_W;
	localparam int unsigned OW   = gbsa_pkg::OFFSET_W;
	localparam int unsigned BIW  = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 1;
	localparam int unsigned CNTW = $clog2(MAX_BATCHES + 1);
	localparam int unsigned SW   = $clog2(MAX_SLOTS);
	localparam int unsigned CW   = $clog2(MAX_SLOTS + 1);
	localparam int unsigned DW   = AW + SW;
	localparam int unsigned EW   = AW + CW;
	localparam int unsigned PW   = AW + SW;
	localparam int unsigned STW  = (SW > 1) ? $clog2(SW) : 1;
	localparam int unsigned CMPW = (CNTW > gbsa_pkg::BATCH_W) ? CNTW : gbsa_pkg::BATCH_W;
	localparam int unsigned CMW  = (EW > OW) ? EW : OW;
	localparam int unsigned DCW  = (DW > OW) ? DW : OW;

	gbsa_pkg::gbsa_state_t  state_q, state_d;
	logic [gbsa_pkg::ESIZE_W-1:0] esize_q;
	logic [CNTW-1:0]        bcnt_q, bcnt_d;

	// busy bitmaps, one word per batch
	logic [MAX_SLOTS-1:0]   mem [MAX_BATCHES];
	logic [MAX_SLOTS-1:0]   rd_q;
	logic                   mem_we;
	logic [BIW-1:0]         mem_wa;
	logic [MAX_SLOTS-1:0]   mem_wd;
	logic [BIW-1:0]         addr_q, addr_d;

	logic [AW-1:0]          asz_q, asz_d;
	logic [OW-1:0]          rem_q, rem_d;
	logic [DW-1:0]          den_q, den_d;
	logic [SW-1:0]          quo_q, quo_d;
	logic [STW-1:0]         step_q, step_d;
	logic [EW-1:0]          end_q, end_d;

	gbsa_pkg::gbsa_status_t status_q, status_d;
	logic [BIW-1:0]         bidx_q, bidx_d;
	logic [SW-1:0]          sidx_q, sidx_d;
	logic                   opened_q, opened_d;
	logic [OW-1:0]          boff_q, boff_d;

	logic [MAX_SLOTS-1:0]   mask_w;
	logic [MAX_SLOTS-1:0]   free_w;
	logic [SW-1:0]          lo_w;
	logic                   any_w;
	logic [PW-1:0]          prod_w;
	logic                   qbit_w;
	logic                   reg_hit_w;

	// config port
	assign reg_hit_w = (paddr[gbsa_pkg::PADDR_W-1:2] == gbsa_pkg::REG_ELEMENT_SIZE);
	assign pready    = 1'b1;
	assign prdata    = reg_hit_w ? gbsa_pkg::PDATA_W'(esize_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esize_q <= gbsa_pkg::ESIZE_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit_w) begin
			esize_q <= pwdata[gbsa_pkg::ESIZE_W-1:0];
		end
	end

	// bitmap memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[addr_q];
	end

	// free slots of the batch under scan and the lowest one
	always_comb begin
		mask_w = MAX_SLOTS'(gbsa_pkg::slot_mask(6'(addr_q), MAX_SLOTS));
		free_w = mask_w & ~rd_q;
		any_w  = |free_w;
		lo_w   = '0;
		for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
			if (free_w[i]) begin
				lo_w = SW'(i);
			end
		end
	end

	assign prod_w = PW'(sidx_q) * PW'(asz_q);
	assign qbit_w = (DCW'(rem_q) >= DCW'(den_q));

	always_comb begin
		state_d  = state_q;
		addr_d   = addr_q;
		bcnt_d   = bcnt_q;
		asz_d    = asz_q;
		rem_d    = rem_q;
		den_d    = den_q;
		quo_d    = quo_q;
		step_d   = step_q;
		end_d    = end_q;
		status_d = status_q;
		bidx_d   = bidx_q;
		sidx_d   = sidx_q;
		opened_d = opened_q;
		boff_d   = boff_q;
		mem_we   = 1'b0;
		mem_wa   = addr_q;
		mem_wd   = rd_q;
		done     = 1'b0;
		case (state_q)
			gbsa_pkg::S_IDLE: begin
				if (start) begin
					asz_d    = gbsa_pkg::align_size(esize_q);
					status_d = gbsa_pkg::STATUS_OK;
					bidx_d   = '0;
					sidx_d   = '0;
					opened_d = 1'b0;
					rem_d    = free_offset;
					addr_d   = '0;
					if (cmd == gbsa_pkg::CMD_ALLOC) begin
						if (esize_q == '0) begin
							status_d = gbsa_pkg::STATUS_NOMEM;
							state_d  = gbsa_pkg::S_FIN;
						end else if (bcnt_q == '0) begin
							// nothing open yet: open batch 0 straight away
							mem_we   = 1'b1;
							mem_wa   = '0;
							mem_wd   = MAX_SLOTS'(1);
							bcnt_d   = CNTW'(1);
							opened_d = 1'b1;
							state_d  = gbsa_pkg::S_FIN;
						end else begin
							state_d = gbsa_pkg::S_A_RD;
						end
					end else begin
						if ((CMPW'(free_batch) >= CMPW'(bcnt_q)) || (esize_q == '0)) begin
							status_d = gbsa_pkg::STATUS_INVALID;
							state_d  = gbsa_pkg::S_FIN;
						end else begin
							addr_d  = BIW'(free_batch);
							state_d = gbsa_pkg::S_F_END;
						end
					end
				end
			end
			gbsa_pkg::S_A_RD: begin
				state_d = gbsa_pkg::S_A_CHK;
			end
			gbsa_pkg::S_A_CHK: begin
				if (any_w) begin
					mem_we  = 1'b1;
					mem_wd  = rd_q | (MAX_SLOTS'(1) << lo_w);
					bidx_d  = addr_q;
					sidx_d  = lo_w;
					state_d = gbsa_pkg::S_FIN;
				end else if ((CNTW'(addr_q) + CNTW'(1)) < bcnt_q) begin
					addr_d  = addr_q + BIW'(1);
					state_d = gbsa_pkg::S_A_RD;
				end else if (bcnt_q == CNTW'(MAX_BATCHES)) begin
					status_d = gbsa_pkg::STATUS_NOMEM;
					state_d  = gbsa_pkg::S_FIN;
				end else begin
					// all open slots busy: open the next batch, slot 0 taken
					mem_we   = 1'b1;
					mem_wa   = BIW'(bcnt_q);
					mem_wd   = MAX_SLOTS'(1);
					bidx_d   = BIW'(bcnt_q);
					bcnt_d   = bcnt_q + CNTW'(1);
					opened_d = 1'b1;
					state_d  = gbsa_pkg::S_FIN;
				end
			end
			gbsa_pkg::S_F_END: begin
				end_d   = EW'(asz_q) * EW'(gbsa_pkg::slot_count(6'(addr_q), MAX_SLOTS));
				den_d   = DW'(asz_q) << (SW - 1);
				quo_d   = '0;
				step_d  = STW'(SW - 1);
				state_d = gbsa_pkg::S_F_CHK;
			end
			gbsa_pkg::S_F_CHK: begin
				// offset below batch end keeps the quotient within SW bits
				if (CMW'(rem_q) >= CMW'(end_q)) begin
					status_d = gbsa_pkg::STATUS_INVALID;
					state_d  = gbsa_pkg::S_FIN;
				end else begin
					state_d = gbsa_pkg::S_F_DIV;
				end
			end
			gbsa_pkg::S_F_DIV: begin
				if (qbit_w) begin
					rem_d = rem_q - OW'(den_q);
				end
				quo_d = SW'({quo_q, qbit_w});
				den_d = den_q >> 1;
				if (step_q == '0) begin
					state_d = gbsa_pkg::S_F_CLR;
				end else begin
					step_d = step_q - STW'(1);
				end
			end
			gbsa_pkg::S_F_CLR: begin
				if (rem_q != '0) begin
					status_d = gbsa_pkg::STATUS_INVALID;
				end else begin
					mem_we = 1'b1;
					mem_wd = rd_q & ~(MAX_SLOTS'(1) << quo_q);
				end
				state_d = gbsa_pkg::S_FIN;
			end
			gbsa_pkg::S_FIN: begin
				boff_d  = OW'(prod_w);
				state_d = gbsa_pkg::S_RESP;
			end
			gbsa_pkg::S_RESP: begin
				done    = 1'b1;
				state_d = gbsa_pkg::S_IDLE;
			end
			default: begin
				state_d = gbsa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbsa_pkg::S_IDLE;
			bcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			bcnt_q  <= bcnt_d;
		end
	end

	always_ff @(posedge clk) begin
		addr_q   <= addr_d;
		asz_q    <= asz_d;
		rem_q    <= rem_d;
		den_q    <= den_d;
		quo_q    <= quo_d;
		step_q   <= step_d;
		end_q    <= end_d;
		status_q <= status_d;
		bidx_q   <= bidx_d;
		sidx_q   <= sidx_d;
		opened_q <= opened_d;
		boff_q   <= boff_d;
	end

	assign busy         = (state_q != gbsa_pkg::S_IDLE);
	assign status       = status_q;
	assign batch_index  = gbsa_pkg::BATCH_W'(bidx_q);
	assign slot_index   = gbsa_pkg::SLOT_W'(sidx_q);
	assign byte_offset  = boff_q;
	assign opened_batch = opened_q;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("done strobe longer than one cycle");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != gbsa_pkg::STATUS_OK) |->
		(batch_index == '0) && (slot_index == '0) && (byte_offset == '0) && !opened_batch)
		else $error("nonzero fields on error result");

	a_open_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		done && opened_batch |->
		(status == gbsa_pkg::STATUS_OK) && (slot_index == '0) && (byte_offset == '0))
		else $error("opened batch did not return slot 0");

	a_bcnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(bcnt_q != $past(bcnt_q)) |-> (bcnt_q == $past(bcnt_q) + CNTW'(1)))
		else $error("batch count moved by other than one");

	a_bcnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q <= CNTW'(MAX_BATCHES))
		else $error("batch count beyond limit");
`endif

endmodule

`default_nettype wire
